@@ src/sphere_index_generator_assert.svh @@
// Assertion macros shared by the sphere index generator modules.
// Each macro expects aclk and aresetn in scope.
`ifndef SPHERE_INDEX_GENERATOR_ASSERT_SVH
`define SPHERE_INDEX_GENERATOR_ASSERT_SVH

// Same-cycle implication.
`define SIG_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SIG_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/sig_pkg.sv @@
// Shared types and constants of the sphere index generator.
package sig_pkg;

    localparam logic [7:0] MAX_SUBDIVISIONS   = 8'd254;
    localparam logic [7:0] SUBDIVISIONS_RESET = 8'd16;

    localparam logic REG_SUBDIVISIONS = 1'b0;
    localparam logic REG_STRIP_MODE   = 1'b1;

    // list-mode phases: first triangle 0..2, second triangle 3..5
    localparam logic [2:0] PHASE_FIRST  = 3'd0;
    localparam logic [2:0] PHASE_SECOND = 3'd3;
    localparam logic [2:0] PHASE_LAST   = 3'd5;

    typedef struct packed {
        logic [15:0] vertex_index;
        logic        last_index;
    } result_t;

endpackage

@@ src/sig_core.sv @@
// Mesh walk state, configuration registers and index computation.
`include "sphere_index_generator_assert.svh"

module sig_core import sig_pkg::*; #(
    parameter logic [7:0] SUBDIV_LIMIT = MAX_SUBDIVISIONS
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [7:0] cfg_wdata,
    input  logic       in_fire,
    input  logic       in_restart,
    output logic       res_valid,
    output result_t    res
);

    logic [7:0]  subdiv_reg;
    logic        strip_reg;
    logic [7:0]  run_p_reg;
    logic        run_strip_reg;
    logic [7:0]  row_count_reg;
    logic [7:0]  column_count_reg;
    logic [2:0]  emit_phase_reg;
    logic [15:0] row_base_reg;
    logic        sequence_active_reg;

    logic [7:0]  p_e, row_e, col_e, row_a, col_a, x_odd;
    logic        strip_e, act_e, act_n;
    logic [2:0]  ph_e, ph_a;
    logic [15:0] base_e, base_a, w_e, x_list, idx;
    logic [8:0]  col_inc, col_inc2;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            subdiv_reg <= SUBDIVISIONS_RESET;
            strip_reg  <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_SUBDIVISIONS: begin
                    subdiv_reg <= (cfg_wdata > SUBDIV_LIMIT) ? SUBDIV_LIMIT : cfg_wdata;
                end
                REG_STRIP_MODE: begin
                    strip_reg <= cfg_wdata[0];
                end
                default: begin
                    strip_reg <= strip_reg;
                end
            endcase
        end
    end

    always_comb begin
        p_e     = run_p_reg;
        strip_e = run_strip_reg;
        row_e   = row_count_reg;
        col_e   = column_count_reg;
        ph_e    = emit_phase_reg;
        base_e  = row_base_reg;
        act_e   = sequence_active_reg;
        if (in_restart) begin
            p_e     = subdiv_reg;
            strip_e = strip_reg;
            row_e   = 8'd0;
            col_e   = 8'd0;
            base_e  = 16'd0;
            // list mode skips the first triangle of every top-row quad
            ph_e    = strip_reg ? PHASE_FIRST : PHASE_SECOND;
            act_e   = strip_reg ? (subdiv_reg != 8'd0) : (subdiv_reg > 8'd1);
        end

        w_e    = {8'd0, p_e} + 16'd1;
        x_odd  = p_e - col_e;
        x_list = base_e + {8'd0, col_e};

        if (strip_e) begin
            if (!row_e[0]) begin
                idx = (ph_e == PHASE_FIRST) ? base_e + w_e + {8'd0, col_e}
                                            : base_e + {8'd0, col_e};
            end else begin
                idx = (ph_e == PHASE_FIRST) ? base_e + {8'd0, x_odd}
                                            : base_e + w_e + {8'd0, x_odd};
            end
        end else begin
            case (ph_e) inside
                3'd0:       idx = x_list;
                3'd1:       idx = x_list + w_e;
                3'd2, 3'd3: idx = x_list + 16'd1;
                3'd4:       idx = x_list + w_e;
                default:    idx = x_list + w_e + 16'd1;
            endcase
        end

        row_a   = row_e;
        col_a   = col_e;
        base_a  = base_e;
        ph_a    = ph_e;
        col_inc = {1'b0, col_e} + 9'd1;
        if (strip_e) begin
            ph_a = {2'b00, ~ph_e[0]};
            if (ph_e[0]) begin
                col_a = col_inc[7:0];
                if (col_inc > {1'b0, p_e}) begin
                    col_a  = 8'd0;
                    row_a  = row_e + 8'd1;
                    base_a = base_e + w_e;
                end
            end
        end else begin
            if (ph_e >= PHASE_LAST) begin
                ph_a  = PHASE_FIRST;
                col_a = col_inc[7:0];
                if (col_inc >= {1'b0, p_e}) begin
                    col_a  = 8'd0;
                    row_a  = row_e + 8'd1;
                    base_a = base_e + w_e;
                end
            end else begin
                ph_a = ph_e + 3'd1;
            end
        end

        col_inc2 = {1'b0, col_a} + 9'd1;
        if (!strip_e && row_a < p_e) begin
            if (row_a == 8'd0 && ph_a < PHASE_SECOND) begin
                ph_a = PHASE_SECOND;
            end else if (({1'b0, row_a} + 9'd1) == {1'b0, p_e} && ph_a >= PHASE_SECOND) begin
                // bottom row: second triangle of the quad is skipped
                ph_a  = PHASE_FIRST;
                col_a = col_inc2[7:0];
                if (col_inc2 >= {1'b0, p_e}) begin
                    col_a  = 8'd0;
                    row_a  = row_a + 8'd1;
                    base_a = base_a + w_e;
                end
            end
        end
        act_n = (row_a < p_e);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_p_reg           <= 8'd0;
            run_strip_reg       <= 1'b0;
            row_count_reg       <= 8'd0;
            column_count_reg    <= 8'd0;
            emit_phase_reg      <= PHASE_FIRST;
            row_base_reg        <= 16'd0;
            sequence_active_reg <= 1'b0;
        end else if (in_fire) begin
            run_p_reg     <= p_e;
            run_strip_reg <= strip_e;
            if (act_e) begin
                row_count_reg       <= row_a;
                column_count_reg    <= col_a;
                emit_phase_reg      <= ph_a;
                row_base_reg        <= base_a;
                sequence_active_reg <= act_n;
            end else begin
                row_count_reg       <= row_e;
                column_count_reg    <= col_e;
                emit_phase_reg      <= ph_e;
                row_base_reg        <= base_e;
                sequence_active_reg <= 1'b0;
            end
        end
    end

    assign res_valid        = in_fire & act_e;
    assign res.vertex_index = idx;
    assign res.last_index   = ~act_n;

    `SIG_ASSERT_IMP(a_active_in_range, sequence_active_reg, row_count_reg < run_p_reg,
        "active mesh with row past the grid")
    `SIG_ASSERT_IMP(a_top_row_skip,
        sequence_active_reg && !run_strip_reg && row_count_reg == 8'd0,
        emit_phase_reg >= PHASE_SECOND, "list mode top row on a skipped triangle")
    `SIG_ASSERT_NXT(a_last_goes_idle, res_valid && res.last_index, !sequence_active_reg,
        "mesh still active after its last index")

endmodule

@@ src/sig_out_stage.sv @@
// Result register with skid stage for the master-side stream.
`include "sphere_index_generator_assert.svh"

module sig_out_stage import sig_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push,
    input  result_t     push_data,
    output logic        in_ready,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,
    output logic        m_tlast
);

    result_t main_reg;
    result_t skid_reg;
    logic    main_valid_reg;
    logic    skid_valid_reg;
    logic    pop;

    assign pop = main_valid_reg & m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (pop) begin
                main_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end else if (push) begin
            if (!main_valid_reg || pop) begin
                main_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (pop) begin
            main_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (pop) begin
                main_reg <= skid_reg;
            end
        end else if (push) begin
            if (!main_valid_reg || pop) begin
                main_reg <= push_data;
            end else begin
                skid_reg <= push_data;
            end
        end
    end

    assign in_ready = ~skid_valid_reg;
    assign m_tvalid = main_valid_reg;
    assign m_tdata  = main_reg.vertex_index;
    assign m_tlast  = main_reg.last_index;

    `SIG_ASSERT_IMP(a_skid_behind_main, skid_valid_reg, main_valid_reg,
        "skid entry held with empty output register")
    `SIG_ASSERT_IMP(a_no_push_when_full, skid_valid_reg, !push,
        "transaction pushed into a full output stage")
    `SIG_ASSERT_NXT(a_hold_while_stalled, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tlast),
        "stalled output transaction changed")

endmodule

@@ src/sphere_index_generator.sv @@
// A result passes through the output stage's main register (or skid register) to m_*.
// Throughput: one transaction per cycle while s_tready is high (skid register empty).
// A two-entry output stage keeps s_tready high while one result waits downstream.
// Reset (aresetn low, synchronous): mesh goes idle, subdivisions = 16, strip_mode = 0,
// output stage empties. No index is produced until a restart transaction arrives.
// Top level of the sphere index generator.
module sphere_index_generator import sig_pkg::*; #(
    parameter logic [7:0] SUBDIV_LIMIT = MAX_SUBDIVISIONS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [0] restart, [7:1] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] vertex_index
    output logic        m_tlast    // last_index
);

    logic    in_fire;
    logic    res_valid;
    result_t res;

    assign in_fire = s_tvalid & s_tready;

    sig_core #(
        .SUBDIV_LIMIT (SUBDIV_LIMIT)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .in_fire    (in_fire),
        .in_restart (s_tdata[0]),
        .res_valid  (res_valid),
        .res        (res)
    );

    sig_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_valid),
        .push_data (res),
        .in_ready  (s_tready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule
